[src/mqr_pkg.sv]
// Package for the multi-queue ring FIFO core.
// Holds the default sizes, action and status codes, payload structs and the
// controller state type shared by all modules of the block.
package mqr_pkg;

	localparam int MQR_QUEUE_DEPTH = 32;
	localparam int MQR_QUEUE_COUNT = 4;

	localparam logic [1:0] ACT_PUSH  = 2'd0;
	localparam logic [1:0] ACT_POP   = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0] action;
		logic [1:0] queue_select;
		logic [7:0] packet_handle;
	} mqr_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic       handle_valid;
		logic [7:0] out_handle;
		logic [4:0] count;
	} mqr_result_t;

	typedef struct packed {
		logic load;
		logic exec;
	} mqr_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP
	} mqr_state_t;

endpackage

[src/mqr_ctrl.sv]
// Controller state machine of the multi-queue ring FIFO core.
// Depends on mqr_pkg for the state type and the command struct.
module mqr_ctrl
	import mqr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output mqr_cmd_t cmd
);

	mqr_state_t state_q;
	mqr_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		busy     = 1'b1;
		done     = 1'b0;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_nx = ST_RESP;
			end
			ST_RESP: begin
				done     = 1'b1;
				state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

endmodule

[src/mqr_datapath.sv]
// Datapath of the multi-queue ring FIFO core: slot memory, queue pointers
// and result registers. Depends on mqr_pkg for codes and payload structs.
module mqr_datapath
	import mqr_pkg::*;
#(
	parameter int QUEUE_DEPTH = MQR_QUEUE_DEPTH,
	parameter int QUEUE_COUNT = MQR_QUEUE_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  mqr_cmd_t    cmd,
	input  mqr_item_t   item,
	output mqr_result_t result
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

	logic [7:0]    mem [QUEUE_COUNT][QUEUE_DEPTH];
	logic [PW-1:0] wp_q [QUEUE_COUNT];
	logic [PW-1:0] rp_q [QUEUE_COUNT];

	logic [1:0]    action_q;
	logic [1:0]    qsel_q;
	logic [7:0]    handle_q;

	logic [1:0]    status_q;
	logic          valid_q;
	logic [4:0]    count_q;
	logic          byp_q;
	logic [7:0]    rd_q;

	logic [QW-1:0] q;
	logic [PW-1:0] wp;
	logic [PW-1:0] rp;
	logic [PW-1:0] wp_nx;
	logic [PW-1:0] rp_nx;
	logic [PW-1:0] wp_new;
	logic [PW-1:0] rp_new;
	logic          full;
	logic          empty;
	logic          do_push;
	logic          do_pop;
	logic [1:0]    status;
	logic          valid;
	logic [PW:0]   diff;
	logic [PW+5:0] diff_ext;

	always_comb begin
		q       = (int'(qsel_q) < QUEUE_COUNT) ? qsel_q[QW-1:0] : '0;
		wp      = wp_q[q];
		rp      = rp_q[q];
		wp_nx   = (wp == PW'(QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
		rp_nx   = (rp == PW'(QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
		full    = (wp_nx == rp);
		empty   = (wp == rp);
		do_push = (action_q == ACT_PUSH) && !full;
		do_pop  = (action_q == ACT_POP) && !empty;
		wp_new  = do_push ? wp_nx : wp;
		rp_new  = do_pop ? rp_nx : rp;
		if ((action_q == ACT_PUSH) && full) begin
			status = STS_FULL;
		end else if ((action_q == ACT_POP) && empty) begin
			status = STS_EMPTY;
		end else begin
			status = STS_OK;
		end
		valid = do_pop || (wp_new != rp_new);
		if (wp_new >= rp_new) begin
			diff = {1'b0, wp_new} - {1'b0, rp_new};
		end else begin
			diff = {1'b0, wp_new} + (PW+1)'(QUEUE_DEPTH) - {1'b0, rp_new};
		end
		diff_ext = (PW+6)'(diff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUEUE_COUNT; i++) begin
				wp_q[i] <= '0;
				rp_q[i] <= '0;
			end
		end else if (cmd.exec) begin
			wp_q[q] <= wp_new;
			rp_q[q] <= rp_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && do_push) begin
			mem[q][wp] <= handle_q;
		end
		if (cmd.exec) begin
			rd_q <= mem[q][rp];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= item.action;
			qsel_q   <= item.queue_select;
			handle_q <= item.packet_handle;
		end
		if (cmd.exec) begin
			status_q <= status;
			valid_q  <= valid;
			count_q  <= diff_ext[4:0];
			byp_q    <= do_push && empty;
		end
	end

	// A push into an empty queue makes the new handle the oldest one.
	always_comb begin
		result.status       = status_q;
		result.handle_valid = valid_q;
		result.count        = count_q;
		if (!valid_q) begin
			result.out_handle = '0;
		end else if (byp_q) begin
			result.out_handle = handle_q;
		end else begin
			result.out_handle = rd_q;
		end
	end

endmodule

[src/multi_queue_ring_fifo_core.sv]
// Top level of the multi-queue ring FIFO core.
// Depends on mqr_pkg, mqr_ctrl and mqr_datapath.
//
//   channel   handshake           payload
//   command   start, busy         item   (mqr_item_t)
//   result    done                result (mqr_result_t)
//
// A command is taken when start is high and busy is low. Each transfer runs
// through capture, then the pointer update, slot write and slot read on the
// memory's write and read ports, and then the result on the ports. The result
// is valid while done is high, for exactly one cycle, and the receiver cannot
// stall it. Reset clears all queue pointers, so every queue starts empty; no
// memory clearing pass is needed.
module multi_queue_ring_fifo_core
	import mqr_pkg::*;
#(
	parameter int QUEUE_DEPTH = MQR_QUEUE_DEPTH,
	parameter int QUEUE_COUNT = MQR_QUEUE_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  mqr_item_t   item,
	output logic        done,
	output mqr_result_t result
);

	mqr_cmd_t cmd;

	mqr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	mqr_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.QUEUE_COUNT (QUEUE_COUNT)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.result (result)
	);

endmodule
